@@ src/tvp_pkg.sv @@
package tvp_pkg;

  localparam int CFG_ADDR_W = 4;

  localparam logic [1:0] REG_PATH_LENGTH = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CMP,
    S_SQRT,
    S_TACC_LD,
    S_TACC_DIV,
    S_COV_LO,
    S_COV_HI,
    S_COV_CHK,
    S_TFLAT_DIV,
    S_VEND_LO,
    S_VEND_HI,
    S_VEND_SAVE,
    S_HEAD_LO,
    S_HEAD_HI,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    R_ZERO,
    R_END,
    R_ACC,
    R_CRUISE,
    R_BRAKE
  } region_t;

endpackage

@@ src/tvp_derive.sv @@
module tvp_derive import tvp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   recalc,
  input  logic [31:0]            len,
  input  logic [31:0]            vlim,
  input  logic [31:0]            acc,
  output logic                   busy,
  output logic [31:0]            acc_eff,
  output logic [31:0]            peak,
  output logic [32+FRAC_BITS-1:0] t_acc,
  output logic [32+FRAC_BITS:0]   t_ca,
  output logic [33+FRAC_BITS:0]   total,
  output logic [32:0]            head
);

  localparam int TW = 32 + FRAC_BITS;
  localparam int MW = 64 + FRAC_BITS;
  localparam int CW = $clog2(TW + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [63:0]     la_r, la_nxt;
  logic            tri_r, tri_nxt;
  logic [63:0]     sq_x_r, sq_x_nxt;
  logic [32:0]     sq_rem_r, sq_rem_nxt;
  logic [31:0]     root_r, root_nxt;
  logic [31:0]     peak_r, peak_nxt;
  logic [TW-1:0]   div_n_r, div_n_nxt;
  logic [TW-1:0]   div_q_r, div_q_nxt;
  logic [31:0]     div_rem_r, div_rem_nxt;
  logic [TW-1:0]   t_acc_r, t_acc_nxt;
  logic [TW-1:0]   t_flat_r, t_flat_nxt;
  logic [MW-1:0]   mulacc_r, mulacc_nxt;
  logic [31:0]     vend_r, vend_nxt;
  logic [32:0]     head_r, head_nxt;
  logic [TW:0]     tca_r, tca_nxt;
  logic [TW+1:0]   total_r, total_nxt;

  logic [31:0]     acc_e, vlim_e;
  logic [31:0]     m_x, m_y;
  logic [63:0]     prod;
  logic [31:0]     tacc_hi;
  logic [34:0]     sq_rs, sq_trial;
  logic [32:0]     sq_rem_step;
  logic [31:0]     root_step;
  logic [31:0]     div_d;
  logic [32:0]     div_rs, div_diff;
  logic            div_ge;
  logic [TW-1:0]   div_q_step;
  logic [63:0]     covered;

  assign acc_e   = (acc == 32'd0) ? 32'd1 : acc;
  assign vlim_e  = (vlim == 32'd0) ? 32'd1 : vlim;
  assign tacc_hi = 32'(t_acc_r[TW-1:32]);
  assign prod    = m_x * m_y;
  assign covered = mulacc_r[MW-1:FRAC_BITS];

  // One step of the digit-by-digit square root: two radicand bits per step.
  assign sq_rs       = {sq_rem_r, sq_x_r[63:62]};
  assign sq_trial    = {1'b0, root_r, 2'b01};
  assign sq_rem_step = (sq_rs >= sq_trial) ? 33'(sq_rs - sq_trial) : sq_rs[32:0];
  assign root_step   = (sq_rs >= sq_trial) ? {root_r[30:0], 1'b1} : {root_r[30:0], 1'b0};

  // One step of restoring division: one quotient bit per step.
  assign div_d      = (state_r == S_TACC_DIV) ? acc_e : peak_r;
  assign div_rs     = {div_rem_r, div_n_r[TW-1]};
  assign div_ge     = div_rs >= {1'b0, div_d};
  assign div_diff   = div_rs - {1'b0, div_d};
  assign div_q_step = {div_q_r[TW-2:0], div_ge};

  always_comb begin
    case (state_r)
      S_PREP:    begin m_x = len;    m_y = acc_e;             end
      S_CMP:     begin m_x = vlim_e; m_y = vlim_e;            end
      S_COV_LO:  begin m_x = peak_r; m_y = t_acc_r[31:0];     end
      S_COV_HI:  begin m_x = peak_r; m_y = tacc_hi;           end
      S_VEND_LO: begin m_x = acc_e;  m_y = t_acc_r[31:0];     end
      S_VEND_HI: begin m_x = acc_e;  m_y = tacc_hi;           end
      S_HEAD_LO: begin m_x = vend_r; m_y = t_acc_r[31:0];     end
      S_HEAD_HI: begin m_x = vend_r; m_y = tacc_hi;           end
      default:   begin m_x = 32'd0;  m_y = 32'd0;             end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    la_nxt      = la_r;
    tri_nxt     = tri_r;
    sq_x_nxt    = sq_x_r;
    sq_rem_nxt  = sq_rem_r;
    root_nxt    = root_r;
    peak_nxt    = peak_r;
    div_n_nxt   = div_n_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    t_acc_nxt   = t_acc_r;
    t_flat_nxt  = t_flat_r;
    mulacc_nxt  = mulacc_r;
    vend_nxt    = vend_r;
    head_nxt    = head_r;
    tca_nxt     = tca_r;
    total_nxt   = total_r;

    case (state_r)
      S_IDLE: begin
      end
      S_PREP: begin
        la_nxt    = prod;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        tri_nxt = prod >= la_r;
        if (prod >= la_r) begin
          sq_x_nxt   = la_r;
          sq_rem_nxt = 33'd0;
          root_nxt   = 32'd0;
          cnt_nxt    = CW'(31);
          state_nxt  = S_SQRT;
        end else begin
          peak_nxt  = vlim_e;
          state_nxt = S_TACC_LD;
        end
      end
      S_SQRT: begin
        sq_x_nxt   = {sq_x_r[61:0], 2'b00};
        sq_rem_nxt = sq_rem_step;
        root_nxt   = root_step;
        cnt_nxt    = cnt_r - CW'(1);
        if (cnt_r == CW'(0)) begin
          peak_nxt  = (root_step == 32'd0) ? 32'd1 : root_step;
          state_nxt = S_TACC_LD;
        end
      end
      S_TACC_LD: begin
        div_n_nxt   = {peak_r, {FRAC_BITS{1'b0}}};
        div_q_nxt   = '0;
        div_rem_nxt = 32'd0;
        cnt_nxt     = CW'(TW - 1);
        state_nxt   = S_TACC_DIV;
      end
      S_TACC_DIV: begin
        div_n_nxt   = {div_n_r[TW-2:0], 1'b0};
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_ge ? div_diff[31:0] : div_rs[31:0];
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(0)) begin
          t_acc_nxt = div_q_step;
          if (tri_r) begin
            t_flat_nxt = '0;
            state_nxt  = S_VEND_LO;
          end else begin
            state_nxt = S_COV_LO;
          end
        end
      end
      S_COV_LO: begin
        mulacc_nxt = MW'(prod);
        state_nxt  = S_COV_HI;
      end
      S_COV_HI: begin
        mulacc_nxt = mulacc_r + (MW'(prod) << 32);
        state_nxt  = S_COV_CHK;
      end
      S_COV_CHK: begin
        if (covered >= 64'(len)) begin
          t_flat_nxt = '0;
          state_nxt  = S_VEND_LO;
        end else begin
          div_n_nxt   = {len - covered[31:0], {FRAC_BITS{1'b0}}};
          div_q_nxt   = '0;
          div_rem_nxt = 32'd0;
          cnt_nxt     = CW'(TW - 1);
          state_nxt   = S_TFLAT_DIV;
        end
      end
      S_TFLAT_DIV: begin
        div_n_nxt   = {div_n_r[TW-2:0], 1'b0};
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_ge ? div_diff[31:0] : div_rs[31:0];
        cnt_nxt     = cnt_r - CW'(1);
        if (cnt_r == CW'(0)) begin
          t_flat_nxt = div_q_step;
          state_nxt  = S_VEND_LO;
        end
      end
      S_VEND_LO: begin
        mulacc_nxt = MW'(prod);
        state_nxt  = S_VEND_HI;
      end
      S_VEND_HI: begin
        mulacc_nxt = mulacc_r + (MW'(prod) << 32);
        state_nxt  = S_VEND_SAVE;
      end
      S_VEND_SAVE: begin
        // a*t_acc never exceeds peak scaled up, so the speed fits in 32 bits.
        vend_nxt  = mulacc_r[FRAC_BITS+31:FRAC_BITS];
        state_nxt = S_HEAD_LO;
      end
      S_HEAD_LO: begin
        mulacc_nxt = MW'(prod);
        state_nxt  = S_HEAD_HI;
      end
      S_HEAD_HI: begin
        mulacc_nxt = mulacc_r + (MW'(prod) << 32);
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (|mulacc_r[MW-1:FRAC_BITS+34]) begin
          head_nxt = '1;
        end else begin
          head_nxt = mulacc_r[FRAC_BITS+33:FRAC_BITS+1];
        end
        tca_nxt   = (TW+1)'(t_acc_r) + (TW+1)'(t_flat_r);
        total_nxt = (TW+2)'({t_acc_r, 1'b0}) + (TW+2)'(t_flat_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_PREP;
      end
    endcase

    if (recalc) begin
      state_nxt = S_PREP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_PREP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    la_r      <= la_nxt;
    tri_r     <= tri_nxt;
    sq_x_r    <= sq_x_nxt;
    sq_rem_r  <= sq_rem_nxt;
    root_r    <= root_nxt;
    peak_r    <= peak_nxt;
    div_n_r   <= div_n_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    t_acc_r   <= t_acc_nxt;
    t_flat_r  <= t_flat_nxt;
    mulacc_r  <= mulacc_nxt;
    vend_r    <= vend_nxt;
    head_r    <= head_nxt;
    tca_r     <= tca_nxt;
    total_r   <= total_nxt;
  end

  assign busy    = state_r != S_IDLE;
  assign acc_eff = acc_e;
  assign peak    = peak_r;
  assign t_acc   = t_acc_r;
  assign t_ca    = tca_r;
  assign total   = total_r;
  assign head    = head_r;

endmodule

@@ src/tvp_eval.sv @@
module tvp_eval import tvp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [31:0]             in_t,
  input  logic [31:0]             len,
  input  logic [31:0]             acc_eff,
  input  logic [31:0]             peak,
  input  logic [32+FRAC_BITS-1:0] t_acc,
  input  logic [32+FRAC_BITS:0]   t_ca,
  input  logic [33+FRAC_BITS:0]   total,
  input  logic [32:0]             head,
  output logic                    out_strobe,
  output logic [31:0]             out_position,
  output logic [31:0]             out_velocity,
  output logic signed [32:0]      out_acceleration
);

  localparam int TW = 32 + FRAC_BITS;
  localparam int CRW = 64 - FRAC_BITS;
  localparam int SW = 65 - FRAC_BITS;
  localparam int DW = 63 - FRAC_BITS;

  region_t           reg0;
  logic [31:0]       x0;

  logic              vld1_r;
  region_t           reg1_r;
  logic [31:0]       x1_r;

  logic              vld2_r;
  region_t           reg2_r;
  logic [31:0]       x2_r;
  logic [63:0]       prod1_r;
  logic [31:0]       mop;

  logic              vld3_r;
  region_t           reg3_r;
  logic [31:0]       vel3_r;
  logic [CRW-1:0]    cru3_r;
  logic [63:0]       prod2_r;
  logic [31:0]       vel2;

  logic [31:0]       pos_nxt, vel_nxt;
  logic [32:0]       accel_nxt;
  logic [SW-1:0]     sum;
  logic [DW-1:0]     drop;
  logic [31:0]       half;

  logic              strobe_r;
  logic [31:0]       pos_r, vel_r;
  logic [32:0]       accel_r;

  // Stage 1: find the profile segment and the time operand.
  always_comb begin
    if (len == 32'd0 || total == '0 || in_t == 32'd0) begin
      reg0 = R_ZERO;
    end else if ((TW+2)'(in_t) >= total) begin
      reg0 = R_END;
    end else if (TW'(in_t) < t_acc) begin
      reg0 = R_ACC;
    end else if ((TW+1)'(in_t) < t_ca) begin
      reg0 = R_CRUISE;
    end else begin
      reg0 = R_BRAKE;
    end
    case (reg0)
      R_CRUISE: x0 = in_t - t_acc[31:0];
      R_BRAKE:  x0 = total[31:0] - in_t;
      default:  x0 = in_t;
    endcase
  end

  assign mop  = (reg1_r == R_CRUISE) ? peak : acc_eff;
  assign vel2 = prod1_r[FRAC_BITS+31:FRAC_BITS];

  always_ff @(posedge clk) begin
    x1_r    <= x0;
    reg1_r  <= reg0;
    prod1_r <= mop * x1_r;
    x2_r    <= x1_r;
    reg2_r  <= reg1_r;
    prod2_r <= vel2 * x2_r;
    vel3_r  <= vel2;
    cru3_r  <= prod1_r[63:FRAC_BITS];
    reg3_r  <= reg2_r;
    pos_r   <= pos_nxt;
    vel_r   <= vel_nxt;
    accel_r <= accel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r   <= 1'b0;
      vld2_r   <= 1'b0;
      vld3_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld1_r   <= in_valid;
      vld2_r   <= vld1_r;
      vld3_r   <= vld2_r;
      strobe_r <= vld3_r;
    end
  end

  assign sum  = SW'(head) + SW'(cru3_r);
  assign drop = prod2_r[63:FRAC_BITS+1];
  assign half = prod2_r[FRAC_BITS+32:FRAC_BITS+1];

  always_comb begin
    pos_nxt   = 32'd0;
    vel_nxt   = 32'd0;
    accel_nxt = 33'd0;
    case (reg3_r)
      R_END: begin
        pos_nxt = len;
      end
      R_ACC: begin
        vel_nxt   = vel3_r;
        pos_nxt   = (|prod2_r[63:FRAC_BITS+33]) ? 32'hFFFF_FFFF : half;
        accel_nxt = {1'b0, acc_eff};
      end
      R_CRUISE: begin
        vel_nxt = peak;
        pos_nxt = (|sum[SW-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
      end
      R_BRAKE: begin
        vel_nxt   = vel3_r;
        // Overshoot past the start clamps the position at zero.
        pos_nxt   = (drop >= DW'(len)) ? 32'd0 : len - half;
        accel_nxt = 33'd0 - {1'b0, acc_eff};
      end
      default: begin
      end
    endcase
  end

  assign out_strobe       = strobe_r;
  assign out_position     = pos_r;
  assign out_velocity     = vel_r;
  assign out_acceleration = accel_r;

endmodule

@@ src/trapezoid_velocity_profile.sv @@
// A request accepted at a clock edge passes through the tvp_eval pipeline registers
// and shows its result on the out_ ports for one cycle, marked by out_strobe; one
// request per cycle while busy is low. After reset and after every register write the
// profile times are rebuilt by a shared sqrt/divide/multiply sequencer; busy is high
// during that time and start is ignored. Here the receiver cannot stall.
module trapezoid_velocity_profile import tvp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           in_sample_time,
  output logic                  out_strobe,
  output logic [31:0]           out_position,
  output logic [31:0]           out_velocity,
  output logic signed [32:0]    out_acceleration
);

  localparam int TW = 32 + FRAC_BITS;

  logic [31:0]   path_length_r;
  logic [31:0]   speed_limit_r;
  logic [31:0]   accel_limit_r;
  logic          wr_en;
  logic          calc_busy;
  logic [31:0]   acc_eff;
  logic [31:0]   peak;
  logic [TW-1:0] t_acc;
  logic [TW:0]   t_ca;
  logic [TW+1:0] total;
  logic [32:0]   head;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_length_r <= 32'd0;
      speed_limit_r <= 32'd1 << FRAC_BITS;
      accel_limit_r <= 32'd1 << FRAC_BITS;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PATH_LENGTH: path_length_r <= pwdata;
        REG_SPEED_LIMIT: speed_limit_r <= pwdata;
        REG_ACCEL_LIMIT: accel_limit_r <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PATH_LENGTH: prdata = path_length_r;
      REG_SPEED_LIMIT: prdata = speed_limit_r;
      REG_ACCEL_LIMIT: prdata = accel_limit_r;
      default:         prdata = 32'd0;
    endcase
  end

  tvp_derive #(.FRAC_BITS(FRAC_BITS)) u_derive (
    .clk     (clk),
    .rst_n   (rst_n),
    .recalc  (wr_en),
    .len     (path_length_r),
    .vlim    (speed_limit_r),
    .acc     (accel_limit_r),
    .busy    (calc_busy),
    .acc_eff (acc_eff),
    .peak    (peak),
    .t_acc   (t_acc),
    .t_ca    (t_ca),
    .total   (total),
    .head    (head)
  );

  assign busy = calc_busy;

  tvp_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (start & ~calc_busy),
    .in_t             (in_sample_time),
    .len              (path_length_r),
    .acc_eff          (acc_eff),
    .peak             (peak),
    .t_acc            (t_acc),
    .t_ca             (t_ca),
    .total            (total),
    .head             (head),
    .out_strobe       (out_strobe),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_acceleration (out_acceleration)
  );

endmodule
